[hw/rtl/pn_pkg.sv]
// ----------------------------------------------------------------------------
// Peak normalizer package
// Shared codes and the classification record passed from front to back.
// ----------------------------------------------------------------------------
package pn_pkg;

    localparam logic FUNC_MEASURE = 1'b0;
    localparam logic FUNC_SCALE   = 1'b1;

    typedef struct packed {
        logic neg;
        logic use_max;
        logic pass;
        logic last;
    } t_cls;

endpackage

[hw/rtl/pn_if.sv]
// ----------------------------------------------------------------------------
// Peak normalizer stream interfaces
// Valid/ready channels for sample beats in and scaled beats out.
// ----------------------------------------------------------------------------
interface pn_in_if #(
    parameter int SB = 16
);
    logic                 valid;
    logic                 ready;
    logic                 func;
    logic signed [SB-1:0] sample;
    logic                 region_end;

    modport source (output valid, output func, output sample, output region_end,
                    input ready);
    modport sink   (input valid, input func, input sample, input region_end,
                    output ready);
endinterface

interface pn_out_if #(
    parameter int SB = 16
);
    logic                 valid;
    logic                 ready;
    logic signed [SB-1:0] scaled;
    logic                 last;

    modport source (output valid, output scaled, output last, input ready);
    modport sink   (input valid, input scaled, input last, output ready);
endinterface

[hw/rtl/pn_queue.sv]
// ----------------------------------------------------------------------------
// Peak normalizer work queue
// Two-entry queue that decouples the classifying front from the divider.
// ----------------------------------------------------------------------------
module pn_queue #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic [W-1:0] i_data,
    output logic         o_valid,
    input  logic         i_ready,
    output logic [W-1:0] o_data
);
    logic         r_v0;
    logic         r_v1;
    logic [W-1:0] r_d0;
    logic [W-1:0] r_d1;
    logic         push;
    logic         pop;

    assign o_ready = !r_v1;
    assign o_valid = r_v0;
    assign o_data  = r_d0;
    assign push    = i_valid && !r_v1;
    assign pop     = r_v0 && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else if (pop) begin
            if (r_v1) begin
                r_d0 <= r_d1;
                r_v1 <= 1'b0;
            end else begin
                r_d0 <= i_data;
                r_v0 <= push;
            end
        end else if (push) begin
            if (!r_v0) begin
                r_d0 <= i_data;
                r_v0 <= 1'b1;
            end else begin
                r_d1 <= i_data;
                r_v1 <= 1'b1;
            end
        end
    end

    a_tail_needs_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 |-> r_v0)
        else $error("queue tail entry valid while head is empty");

endmodule

[hw/rtl/pn_front.sv]
// ----------------------------------------------------------------------------
// Peak normalizer front end
// Tracks the peaks in the measure pass and classifies scale pass beats.
// ----------------------------------------------------------------------------
module pn_front #(
    parameter int SB = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pn_in_if.sink         i_in,
    output logic          o_valid,
    input  logic          i_ready,
    output pn_pkg::t_cls  o_cls,
    output logic [SB-1:0] o_mag,
    output logic [SB-1:0] o_den,
    output logic [SB-1:0] o_raw
);
    import pn_pkg::*;

    localparam int PW = 2 * SB - 1;

    logic [SB-2:0] r_pp;
    logic [SB-1:0] r_pn;
    logic          accept;
    logic          neg;
    logic [SB-1:0] raw;
    logic [SB-1:0] mag;
    logic [PW-1:0] lhs;
    logic [PW-1:0] rhs;
    logic          use_max;
    logic          pass;

    assign i_in.ready = i_ready;
    assign accept     = i_in.valid && i_ready;

    assign raw = i_in.sample;
    assign neg = raw[SB-1];
    assign mag = neg ? (~raw + 1'b1) : raw;

    assign lhs     = {r_pn, {(SB-1){1'b0}}} - {{(SB-1){1'b0}}, r_pn};
    assign rhs     = {1'b0, r_pp, {(SB-1){1'b0}}};
    assign pass    = (r_pp == '0) && (r_pn == '0);
    assign use_max = (r_pp != '0) && ((r_pn == '0) || (lhs <= rhs));

    assign o_valid       = i_in.valid && (i_in.func == FUNC_SCALE);
    assign o_cls.neg     = neg;
    assign o_cls.use_max = use_max;
    assign o_cls.pass    = pass;
    assign o_cls.last    = i_in.region_end;
    assign o_mag         = mag;
    assign o_den         = use_max ? {1'b0, r_pp} : r_pn;
    assign o_raw         = raw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pp <= '0;
            r_pn <= '0;
        end else if (accept) begin
            if (i_in.func == FUNC_MEASURE) begin
                if (neg && (mag > r_pn)) begin
                    r_pn <= mag;
                end
                if (!neg && (mag[SB-2:0] > r_pp)) begin
                    r_pp <= mag[SB-2:0];
                end
            end else if (i_in.region_end) begin
                r_pp <= '0;
                r_pn <= '0;
            end
        end
    end

    a_peaks_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_in.func == FUNC_SCALE) && i_in.region_end)
        |=> (r_pp == '0) && (r_pn == '0))
        else $error("peaks not cleared after the last scale beat");

endmodule

[hw/rtl/pn_back.sv]
// ----------------------------------------------------------------------------
// Peak normalizer back end
// Scales one classified beat with a restoring divider and holds the result.
// ----------------------------------------------------------------------------
module pn_back #(
    parameter int SB = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    output logic          o_q_ready,
    input  pn_pkg::t_cls  i_cls,
    input  logic [SB-1:0] i_mag,
    input  logic [SB-1:0] i_den,
    input  logic [SB-1:0] i_raw,
    pn_out_if.source      o_out
);
    import pn_pkg::*;

    localparam int PW = 2 * SB - 1;
    localparam int CW = $clog2(SB + 1);
    localparam logic [SB-1:0] MINMAG = {1'b1, {(SB-1){1'b0}}};
    localparam logic [SB-1:0] MAXV   = {1'b0, {(SB-1){1'b1}}};
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [1:0]    r_state;
    logic [CW-1:0] r_cnt;
    logic [SB-1:0] r_rem;
    logic [SB-1:0] r_low;
    logic [SB-1:0] r_den;
    logic          r_neg;
    logic          r_last;
    logic [SB-1:0] r_res;
    logic          r_ovalid;
    logic [SB-1:0] r_scaled;
    logic          r_olast;

    logic [PW-1:0] prod;
    logic [SB-2:0] hi;
    logic [SB-1:0] lo;
    logic          sat_ld;
    logic [SB:0]   trial;
    logic [SB:0]   diff;
    logic          ge;
    logic [SB-1:0] n_rem;
    logic [SB-1:0] n_low;
    logic [SB-1:0] q_sat;
    logic [SB-1:0] res_div;
    logic          out_free;

    assign o_q_ready = (r_state == ST_IDLE);

    assign prod   = {i_mag, {(SB-1){1'b0}}}
                  - (i_cls.use_max ? {{(SB-1){1'b0}}, i_mag} : {PW{1'b0}});
    assign hi     = prod[PW-1:SB];
    assign lo     = prod[SB-1:0];
    assign sat_ld = ({1'b0, hi} >= i_den);

    assign trial = {r_rem, r_low[SB-1]};
    assign ge    = (trial >= {1'b0, r_den});
    assign diff  = trial - {1'b0, r_den};
    assign n_rem = ge ? diff[SB-1:0] : trial[SB-1:0];
    assign n_low = {r_low[SB-2:0], ge};

    always_comb begin
        if (r_neg) begin
            q_sat   = (n_low > MINMAG) ? MINMAG : n_low;
            res_div = ~q_sat + 1'b1;
        end else begin
            q_sat   = n_low[SB-1] ? MAXV : n_low;
            res_div = q_sat;
        end
    end

    assign out_free     = !r_ovalid || o_out.ready;
    assign o_out.valid  = r_ovalid;
    assign o_out.scaled = r_scaled;
    assign o_out.last   = r_olast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if ((r_state == ST_HOLD) && out_free) begin
                r_ovalid <= 1'b1;
                r_scaled <= r_res;
                r_olast  <= r_last;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_q_valid) begin
                        r_neg  <= i_cls.neg;
                        r_last <= i_cls.last;
                        if (i_cls.pass) begin
                            r_res   <= i_raw;
                            r_state <= ST_HOLD;
                        end else if (sat_ld) begin
                            r_res   <= i_cls.neg ? MINMAG : MAXV;
                            r_state <= ST_HOLD;
                        end else begin
                            r_rem   <= {1'b0, hi};
                            r_low   <= lo;
                            r_den   <= i_den;
                            r_cnt   <= CW'(SB);
                            r_state <= ST_DIV;
                        end
                    end
                end
                ST_DIV: begin
                    r_rem <= n_rem;
                    r_low <= n_low;
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == CW'(1)) begin
                        r_res   <= res_div;
                        r_state <= ST_HOLD;
                    end
                end
                ST_HOLD: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_rem < r_den))
        else $error("divider remainder not below the divisor");

    a_cnt_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_cnt != '0))
        else $error("divider running with an exhausted step count");

    a_hold_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_HOLD) && out_free) |=> r_ovalid && (r_state == ST_IDLE))
        else $error("finished result not moved to the output register");

endmodule

[hw/rtl/peak_normalizer.sv]
// ----------------------------------------------------------------------------
// Peak normalizer
// Two-pass peak normalization of signed audio samples.
//
//   port    dir   payload                      beat
//   i_in    in    func, sample, region_end     one sample, either pass
//   o_out   out   scaled, last                 one scaled sample
//
// A measure pass beat is taken whenever the work queue has room.
// A scale pass beat goes through the back end in order: a load, SAMPLE_BITS
// restoring divider steps and a hand off to the output register;
// pass-through and saturated beats skip the divider steps.
// The queue holds two scale beats, so the input stalls only when it is full.
// Reset is synchronous and clears the peaks, the queue and the output valid.
// ----------------------------------------------------------------------------
module peak_normalizer #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    pn_in_if.sink    i_in,
    pn_out_if.source o_out
);
    import pn_pkg::*;

    localparam int QW = $bits(t_cls) + 3 * SAMPLE_BITS;

    logic                   f_valid;
    logic                   f_ready;
    t_cls                   f_cls;
    logic [SAMPLE_BITS-1:0] f_mag;
    logic [SAMPLE_BITS-1:0] f_den;
    logic [SAMPLE_BITS-1:0] f_raw;
    logic                   b_valid;
    logic                   b_ready;
    t_cls                   b_cls;
    logic [SAMPLE_BITS-1:0] b_mag;
    logic [SAMPLE_BITS-1:0] b_den;
    logic [SAMPLE_BITS-1:0] b_raw;
    logic [QW-1:0]          q_in;
    logic [QW-1:0]          q_out;

    pn_front #(.SB(SAMPLE_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_valid (f_valid),
        .i_ready (f_ready),
        .o_cls   (f_cls),
        .o_mag   (f_mag),
        .o_den   (f_den),
        .o_raw   (f_raw)
    );

    assign q_in = {f_cls, f_mag, f_den, f_raw};

    pn_queue #(.W(QW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_data  (q_in),
        .o_valid (b_valid),
        .i_ready (b_ready),
        .o_data  (q_out)
    );

    assign {b_cls, b_mag, b_den, b_raw} = q_out;

    pn_back #(.SB(SAMPLE_BITS)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (b_valid),
        .o_q_ready (b_ready),
        .i_cls     (b_cls),
        .i_mag     (b_mag),
        .i_den     (b_den),
        .i_raw     (b_raw),
        .o_out     (o_out)
    );

endmodule
